>>> hdl/mcdt_pkg.sv
// Shared types and constants of the multi-channel debounce and toggle block.
`default_nettype none

package mcdt_pkg;

    // Width of every pin, mask and active-level field.
    localparam int FIELD_W = 6;

    // Width of the per-channel debounce down-count.
    localparam int COUNT_W = 8;

    // Debounce count after reset.
    localparam logic [COUNT_W-1:0] DEBOUNCE_RESET = 8'd10;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_LEVEL = 1'b0,
        CFG_DEBOUNCE     = 1'b1
    } t_cfg_idx;

    // Per-channel debounce states.
    typedef enum logic [3:0] {
        ST_UP      = 4'b0001,
        ST_FALLING = 4'b0010,
        ST_DOWN    = 4'b0100,
        ST_RISING  = 4'b1000
    } t_chan_state;

endpackage : mcdt_pkg

`default_nettype wire

>>> hdl/multi_channel_debounce_toggle_top.sv
// Multi-channel button debouncer with per-channel press toggling.
//
// Usage: each input item on the s_axis channel is one time tick carrying
// the raw pin level of six channels. Each channel runs its own four-state
// debouncer (up, falling, down, rising) and every confirmed press flips a
// per-channel toggle; the m_axis channel returns one item per tick with
// the on mask, the off mask and the debounced level mask.
// The cfg channel writes the active-level mask (index 0) and the debounce
// count (index 1); it is always ready, and the user must see that it is
// written only while idle, which the block itself does not enforce.
// Path: an accepted tick is held in the input register, and its result
// loads into the result register when that register is free.
// Throughput: one item per cycle while the result is not stalled; the
// channel updates are a small state step and a count decrement between the input and result registers.
// Reset: all channels return to up with count and toggle cleared, the
// active-level mask goes to 0 and the debounce count to 10.
// Stall: while m_axis_tready is low the result is held; the input register
// still takes one more item, and then s_axis_tready drops.
`default_nettype none

module multi_channel_debounce_toggle_top
    import mcdt_pkg::*;
#(
    parameter int CHANNELS = 6
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Input ticks; tdata bits: [5:0] pin_levels, [7:6] zero.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,
    // Results; tdata bits: [5:0] press_on_mask, [11:6] press_off_mask,
    // [17:12] debounced_mask, [23:18] zero.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [23:0]                m_axis_tdata,
    // Configuration writes.
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int EXT_W = (CHANNELS > FIELD_W) ? CHANNELS : FIELD_W;

    // Configuration registers.
    logic [FIELD_W-1:0] r_active;
    logic [COUNT_W-1:0] r_debounce;

    // Input register.
    logic               r_in_valid;
    logic [FIELD_W-1:0] r_pins;

    // Per-channel state.
    t_chan_state        r_state  [CHANNELS];
    logic [COUNT_W-1:0] r_count  [CHANNELS];
    logic [CHANNELS-1:0] r_toggle;
    t_chan_state        n_state  [CHANNELS];
    logic [COUNT_W-1:0] n_count  [CHANNELS];
    logic [CHANNELS-1:0] n_toggle;

    // Result register.
    logic               r_out_valid;
    logic [FIELD_W-1:0] r_on;
    logic [FIELD_W-1:0] r_off;
    logic [FIELD_W-1:0] r_held;

    logic               w_advance;
    logic [EXT_W-1:0]   w_pins_ext;
    logic [EXT_W-1:0]   w_act_ext;
    logic [EXT_W-1:0]   n_on_ext;
    logic [EXT_W-1:0]   n_off_ext;
    logic [EXT_W-1:0]   n_held_ext;

    // Handshake: the work stage moves when the result register is free.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_held, r_off, r_on};

    // Channels beyond the field width read pin and active level as zero.
    assign w_pins_ext = EXT_W'(r_pins);
    assign w_act_ext  = EXT_W'(r_active);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_debounce <= DEBOUNCE_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ACTIVE_LEVEL: r_active   <= i_cfg_data[FIELD_W-1:0];
                CFG_DEBOUNCE:     r_debounce <= i_cfg_data[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_pins <= s_axis_tdata[FIELD_W-1:0];
        end
    end

    // Per-channel debounce step for the registered tick.
    always_comb begin
        logic pressed;
        n_on_ext   = '0;
        n_off_ext  = '0;
        n_held_ext = '0;
        n_toggle   = r_toggle;
        for (int c = 0; c < CHANNELS; c++) begin
            pressed    = (w_pins_ext[c] == w_act_ext[c]);
            n_state[c] = r_state[c];
            n_count[c] = r_count[c];
            unique case (r_state[c])
                ST_UP: begin
                    if (pressed) begin
                        n_state[c] = ST_FALLING;
                        n_count[c] = r_debounce;
                    end
                end
                ST_FALLING: begin
                    if (!pressed) begin
                        n_state[c] = ST_UP;
                    end else if (r_count[c] != '0) begin
                        n_count[c] = r_count[c] - 1'b1;
                    end else begin
                        // Confirmed press: flip the toggle and report it.
                        n_state[c]  = ST_DOWN;
                        n_toggle[c] = !r_toggle[c];
                        n_on_ext[c]  = !r_toggle[c];
                        n_off_ext[c] = r_toggle[c];
                    end
                end
                ST_DOWN: begin
                    if (!pressed) begin
                        n_state[c] = ST_RISING;
                        n_count[c] = r_debounce;
                    end
                end
                ST_RISING: begin
                    if (pressed) begin
                        n_state[c] = ST_DOWN;
                    end else if (r_count[c] != '0) begin
                        n_count[c] = r_count[c] - 1'b1;
                    end else begin
                        n_state[c] = ST_UP;
                    end
                end
                default: begin
                    n_state[c] = ST_UP;
                end
            endcase
            n_held_ext[c] = (n_state[c] == ST_DOWN) || (n_state[c] == ST_RISING);
        end
    end

    // Channel state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_toggle <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_state[c] <= ST_UP;
                r_count[c] <= '0;
            end
        end else if (w_advance) begin
            r_toggle <= n_toggle;
            for (int c = 0; c < CHANNELS; c++) begin
                r_state[c] <= n_state[c];
                r_count[c] <= n_count[c];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_on   <= n_on_ext[FIELD_W-1:0];
            r_off  <= n_off_ext[FIELD_W-1:0];
            r_held <= n_held_ext[FIELD_W-1:0];
        end
    end

endmodule : multi_channel_debounce_toggle_top

`default_nettype wire
